// ----- rtl/core/wvma_pkg.sv -----
// wvma_pkg: shared types and constants for the windowed vector moving average
// no dependencies
package wvma_pkg;

  localparam int MaxWindowDefault = 64;
  localparam int MaxDimDefault    = 16;
  localparam int SampleWidth      = 24;
  localparam int CfgWidth         = 7;
  localparam int IndexWidth       = 4;
  localparam int StampWidth       = 32;
  localparam logic [CfgWidth-1:0] WindowReset = 7'd50;

  localparam logic OpSample = 1'b0;
  localparam logic OpTick   = 1'b1;

  typedef struct packed {
    logic                          op;
    logic signed [SampleWidth-1:0] sample_value;
    logic                          end_of_frame;
    logic [StampWidth-1:0]         tick_stamp;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] mean_value;
    logic [IndexWidth-1:0]         element_index;
    logic                          last_element;
    logic [StampWidth-1:0]         result_tick;
  } out_item_t;

endpackage

// ----- rtl/core/wvma_div.sv -----
// wvma_div: shared restoring divider, signed dividend by unsigned divisor,
// one quotient bit per cycle, truncation toward zero; uses wvma_pkg
module wvma_div #(
  parameter int NumWidth = 32,
  parameter int DenWidth = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [NumWidth-1:0] num,
  input  logic [DenWidth-1:0]        den,
  output logic                       done,
  output logic signed [NumWidth-1:0] quo
);
  import wvma_pkg::*;

  localparam int CntWidth = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] mag;
  logic [DenWidth:0]   rem;
  logic [DenWidth-1:0] dv;
  logic                neg;
  logic [CntWidth-1:0] cnt;
  logic                busy;
  logic [DenWidth:0]   rem_sh;
  logic [DenWidth:0]   rem_sub;

  assign rem_sh  = {rem[DenWidth-1:0], mag[NumWidth-1]};
  assign rem_sub = rem_sh - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        mag  <= num[NumWidth-1] ? (-num) : num;
        neg  <= num[NumWidth-1];
        dv   <= den;
        rem  <= '0;
        cnt  <= CntWidth'(NumWidth);
      end else if (busy) begin
        if (rem_sub[DenWidth]) begin
          rem <= rem_sh;
          mag <= {mag[NumWidth-2:0], 1'b0};
        end else begin
          rem <= rem_sub;
          mag <= {mag[NumWidth-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // mag holds the quotient magnitude once finished
  assign quo = neg ? -$signed(mag) : $signed(mag);
endmodule

// ----- rtl/core/windowed_vector_moving_average.sv -----
// windowed_vector_moving_average: top level, sequencer, frame memory, accumulator
// sample: a sample only fills the staging store; a kept frame end also copies its elements to frame memory
// tick, per element: setup, sweep of the held frames, divider start, serial divide, then the result
// throughput: one item at a time, ready low while copying, sweeping, dividing, trimming or holding a result;
// the single memory read port, the serial divider and frame trimming set the rate
// reset: synchronous rst clears control; frame memory is not cleared, only written slots read
module windowed_vector_moving_average #(
  parameter int MAX_WINDOW   = wvma_pkg::MaxWindowDefault,
  parameter int MAX_DIM      = wvma_pkg::MaxDimDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  wvma_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output wvma_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic [wvma_pkg::CfgWidth-1:0] cfg_data
);
  import wvma_pkg::*;

  localparam int SlotW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int ElemW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int HeldW  = $clog2(MAX_WINDOW + 1);
  localparam int LenW   = $clog2(MAX_DIM + 1);
  localparam int SumW   = SampleWidth + HeldW;
  localparam int Depth  = MAX_WINDOW * MAX_DIM;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_COPY, S_READ, S_ACC, S_DIV, S_WAIT, S_OUT
  } state_t;

  state_t state;

  // memories
  logic signed [SampleWidth-1:0] frame_mem [Depth];
  logic signed [SampleWidth-1:0] stage_mem [MAX_DIM];

  logic [SlotW-1:0] oldest_slot;
  logic [HeldW-1:0] frames_held;
  logic [LenW-1:0]  locked_length;
  logic [LenW-1:0]  staging_count;
  logic             staging_overflow;
  logic [CfgWidth-1:0] window_len;

  // sequencer working registers
  logic [ElemW-1:0] elem;
  logic [HeldW-1:0] k;
  logic [SlotW-1:0] slot;
  logic [SlotW-1:0] new_slot;
  logic signed [SumW-1:0] acc;
  logic signed [SampleWidth-1:0] rd_data;
  logic [StampWidth-1:0] stamp;
  logic rd_pend;
  logic div_start, div_done;
  logic signed [SumW-1:0] quo;

  // effective window clamps zero to one and large values to MAX_WINDOW
  logic [HeldW-1:0] eff_win;
  always_comb begin
    if (window_len == '0) eff_win = HeldW'(1);
    else if (32'(window_len) > MAX_WINDOW) eff_win = HeldW'(MAX_WINDOW);
    else eff_win = HeldW'(window_len);
  end

  function automatic logic [SlotW-1:0] slot_add(input logic [SlotW-1:0] a,
                                                input logic [HeldW-1:0] b);
    logic [SlotW+HeldW:0] s;
    s = (SlotW+HeldW+1)'(a) + (SlotW+HeldW+1)'(b);
    if (s >= (SlotW+HeldW+1)'(MAX_WINDOW)) s = s - (SlotW+HeldW+1)'(MAX_WINDOW);
    return SlotW'(s);
  endfunction

  function automatic logic [AddrW-1:0] addr_of(input logic [SlotW-1:0] s,
                                               input logic [ElemW-1:0] e);
    return AddrW'(s) * AddrW'(MAX_DIM) + AddrW'(e);
  endfunction

  // no transfer while the ring still holds more frames than the window allows
  assign in_ready = (state == S_IDLE) && !out_valid && (frames_held <= eff_win);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // sample completion decision
  logic [LenW-1:0] cnt_after;
  logic            ovf_after;
  logic            frame_ok;
  always_comb begin
    ovf_after = staging_overflow;
    cnt_after = staging_count;
    if (32'(staging_count) < MAX_DIM) cnt_after = staging_count + 1'b1;
    else ovf_after = 1'b1;
    frame_ok = !ovf_after && (cnt_after != '0) &&
               ((locked_length == '0) || (cnt_after == locked_length));
  end

  // staging store write
  always_ff @(posedge clk) begin
    if (in_xfer && in_data.op == OpSample && 32'(staging_count) < MAX_DIM)
      stage_mem[ElemW'(staging_count)] <= SampleWidth'(in_data.sample_value);
  end

  // frame memory: write during copy, registered read during sum
  always_ff @(posedge clk) begin
    if (state == S_COPY)
      frame_mem[addr_of(new_slot, elem)] <= stage_mem[elem];
    rd_data <= frame_mem[addr_of(slot, elem)];
  end

  wvma_div #(.NumWidth(SumW), .DenWidth(HeldW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(acc),
    .den(frames_held), .done(div_done), .quo(quo)
  );

  assign div_start = (state == S_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      oldest_slot      <= '0;
      frames_held      <= '0;
      locked_length    <= '0;
      staging_count    <= '0;
      staging_overflow <= 1'b0;
      window_len       <= WindowReset;
      out_valid        <= 1'b0;
      rd_pend          <= 1'b0;
      elem             <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      // config only while idle, user's duty, unenforced; trim one oldest frame per cycle if idle, no cfg_we
      if (cfg_we) begin
        window_len <= cfg_data;
      end else if (state == S_IDLE && frames_held > eff_win) begin
        oldest_slot <= slot_add(oldest_slot, HeldW'(1));
        frames_held <= frames_held - 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_data.op == OpSample) begin
              if (in_data.end_of_frame) begin
                staging_count    <= '0;
                staging_overflow <= 1'b0;
                if (frame_ok) begin
                  locked_length <= cnt_after;
                  new_slot      <= slot_add(oldest_slot, frames_held);
                  elem          <= '0;
                  state         <= S_COPY;
                end
              end else begin
                staging_count    <= cnt_after;
                staging_overflow <= ovf_after;
              end
            end else if (frames_held != '0 && locked_length != '0) begin
              stamp <= in_data.tick_stamp;
              elem  <= '0;
              state <= S_READ;
            end
          end
        end
        S_COPY: begin
          if (LenW'(elem) + 1'b1 == locked_length) begin
            // ring full: overwrite oldest
            if (frames_held == HeldW'(MAX_WINDOW))
              oldest_slot <= slot_add(oldest_slot, HeldW'(1));
            else
              frames_held <= frames_held + 1'b1;
            state <= S_IDLE;
          end else begin
            elem <= elem + 1'b1;
          end
        end
        S_READ: begin
          slot    <= oldest_slot;
          k       <= '0;
          acc     <= '0;
          rd_pend <= 1'b0;
          state   <= S_ACC;
        end
        S_ACC: begin
          // one memory word a cycle, read data arrives in the cycle after its address
          if (rd_pend) acc <= acc + SumW'(rd_data);
          if (k != frames_held) begin
            slot    <= slot_add(slot, HeldW'(1));
            k       <= k + 1'b1;
            rd_pend <= 1'b1;
          end else if (rd_pend) begin
            rd_pend <= 1'b0;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (div_done) begin
            out_data.mean_value    <= SampleWidth'(quo);
            out_data.element_index <= IndexWidth'(elem);
            out_data.last_element  <= (LenW'(elem) + 1'b1 == locked_length);
            out_data.result_tick   <= stamp;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_valid && out_ready) begin
            if (LenW'(elem) + 1'b1 == locked_length) begin
              state <= S_IDLE;
            end else begin
              elem  <= elem + 1'b1;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/wvma_checker.sv -----
// wvma_checker: port level checks for windowed_vector_moving_average
// depends on wvma_pkg; bound to the top level below
module wvma_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input wvma_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input wvma_pkg::out_item_t out_data
);
  import wvma_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no input taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // a sample causes no result next cycle
  a_sample_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.op == OpSample |=> !out_valid)
    else $error("result after sample");

  // nothing emitted right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind windowed_vector_moving_average wvma_checker u_wvma_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);
